### rtl/dtq_pkg.sv
// Deadline timer queue: shared types, codes and constants.
// No dependencies; every other file of the block imports this package.
package dtq_pkg;

  localparam int TIMER_COUNT_DEF = 16;

  localparam int ACT_W     = 2;
  localparam int ID_W      = 4;
  localparam int TIMEOUT_W = 30;
  localparam int TICK_W    = 32;
  localparam int KIND_W    = 2;
  localparam int CFG_W     = 16;

  localparam logic [CFG_W-1:0]  MIN_WAIT_RST = 16'd200;
  localparam logic [TICK_W-1:0] SIGN_BIT     = 32'h8000_0000;

  localparam logic [ACT_W-1:0] ACT_ARM  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_STOP = 2'd1;
  localparam logic [ACT_W-1:0] ACT_POLL = 2'd2;

  localparam logic [KIND_W-1:0] KIND_FIRE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WAIT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ACK  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACK,
    ST_LOAD,
    ST_SETTLE,
    ST_FIRE
  } state_t;

  typedef struct packed {
    logic ins;
    logic pop;
    logic clr;
  } chain_ctl_t;

endpackage

### rtl/dtq_if.sv
// Deadline timer queue: request and result channel interfaces.
// Depends on dtq_pkg for field widths.
interface dtq_req_if import dtq_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [ACT_W-1:0]     action;
  logic [ID_W-1:0]      timer_id;
  logic [TIMEOUT_W-1:0] timeout_ms;
  logic [TICK_W-1:0]    now_tick;

  modport source (output valid, action, timer_id, timeout_ms, now_tick, input ready);
  modport sink   (input valid, action, timer_id, timeout_ms, now_tick, output ready);
endinterface

interface dtq_rsp_if import dtq_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   fired_id;
  logic [TICK_W-1:0] wait_ms;
  logic              last;

  modport source (output valid, kind, fired_id, wait_ms, last, input ready);
  modport sink   (input valid, kind, fired_id, wait_ms, last, output ready);
endinterface

### rtl/deadline_timer_queue.sv
// Deadline timer queue top level: deadline memory, pending bits, control
// and result register. Depends on dtq_pkg, dtq_if and dtq_chain.
//
// Arm and stop requests return one acknowledge. A poll reads the deadline
// memory one timer per cycle into a sorting chain of TIMER_COUNT cells,
// then fires one due timer per cycle from the chain head in deadline order
// while the output register is free, and ends with the wait report. The
// single read port of the deadline memory sets the load time.
// One request is worked on at a time; a new request is taken while the
// last result still waits in the output register.
module deadline_timer_queue import dtq_pkg::*; #(
  parameter int TIMER_COUNT = TIMER_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  dtq_req_if.sink          in_req,
  dtq_rsp_if.source        out_rsp,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(TIMER_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_COUNT - 1);

  state_t state_r, state_nxt;

  logic [TICK_W-1:0]      dl_mem [TIMER_COUNT];
  logic [TIMER_COUNT-1:0] pending_r;
  logic [CFG_W-1:0]       min_wait_r;
  logic [TICK_W-1:0]      now_r;
  logic [IDX_W-1:0]       cnt_r;
  logic                   ld_vld_r;
  logic [IDX_W-1:0]       ld_id_r;
  logic [TICK_W-1:0]      rd_data_r;

  logic              out_vld_r;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [ID_W-1:0]   fid_r, fid_nxt;
  logic [TICK_W-1:0] wait_r, wait_nxt;
  logic              last_r, last_nxt;
  logic              out_ld;

  logic              in_acc;
  logic              out_free;
  logic              id_ok;
  logic [IDX_W-1:0]  req_idx;
  logic              fire_clr;
  chain_ctl_t        ctl;
  logic [TICK_W-1:0] ins_key;
  logic              head_vld;
  logic [TICK_W-1:0] head_key;
  logic [IDX_W-1:0]  head_id;
  logic              head_due;
  logic [TICK_W-1:0] head_d;
  logic [TICK_W-1:0] wait_val;

  assign in_acc   = in_req.valid && in_req.ready;
  assign out_free = !out_vld_r || out_rsp.ready;
  assign id_ok    = 32'(in_req.timer_id) < 32'(TIMER_COUNT);
  assign req_idx  = IDX_W'(in_req.timer_id);

  // signed distance to deadline, offset so unsigned compare gives signed order
  assign ins_key  = (rd_data_r - now_r) ^ SIGN_BIT;
  assign head_due = head_vld && (!head_key[TICK_W-1] || head_key == SIGN_BIT);
  assign head_d   = head_key ^ SIGN_BIT;
  assign wait_val = !head_vld ? '1 :
                    (head_d < 32'(min_wait_r)) ? 32'(min_wait_r) : head_d;

  dtq_chain #(.TIMER_COUNT(TIMER_COUNT), .IDX_W(IDX_W)) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .ins_key  (ins_key),
    .ins_id   (ld_id_r),
    .head_vld (head_vld),
    .head_key (head_key),
    .head_id  (head_id)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_req.ready = 1'b0;
    out_ld       = 1'b0;
    kind_nxt     = KIND_ACK;
    fid_nxt      = '0;
    wait_nxt     = '0;
    last_nxt     = 1'b1;
    fire_clr     = 1'b0;
    ctl.ins      = ld_vld_r;
    ctl.pop      = 1'b0;
    ctl.clr      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_req.ready = 1'b1;
        if (in_req.valid) begin
          state_nxt = (in_req.action == ACT_POLL) ? ST_LOAD : ST_ACK;
        end
      end
      ST_ACK: begin
        if (out_free) begin
          out_ld    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_LOAD: begin
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        state_nxt = ST_FIRE;
      end
      ST_FIRE: begin
        if (out_free) begin
          out_ld = 1'b1;
          if (head_due) begin
            kind_nxt = KIND_FIRE;
            fid_nxt  = ID_W'(head_id);
            last_nxt = 1'b0;
            fire_clr = 1'b1;
            ctl.pop  = 1'b1;
          end else begin
            kind_nxt  = KIND_WAIT;
            wait_nxt  = wait_val;
            ctl.clr   = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_req.action == ACT_ARM && id_ok) begin
      dl_mem[req_idx] <= in_req.now_tick + TICK_W'(in_req.timeout_ms);
    end
    rd_data_r <= dl_mem[cnt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (in_acc && in_req.action == ACT_ARM && id_ok) begin
      pending_r[req_idx] <= 1'b1;
    end else if (in_acc && in_req.action == ACT_STOP && id_ok) begin
      pending_r[req_idx] <= 1'b0;
    end else if (fire_clr) begin
      pending_r[head_id] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_wait_r <= MIN_WAIT_RST;
    end else if (cfg_we) begin
      min_wait_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      ld_vld_r <= 1'b0;
    end else begin
      cnt_r    <= (state_r == ST_LOAD) ? cnt_r + IDX_W'(1) : '0;
      ld_vld_r <= (state_r == ST_LOAD) && pending_r[cnt_r];
    end
  end

  always_ff @(posedge clk) begin
    ld_id_r <= cnt_r;
    if (in_acc) begin
      now_r <= in_req.now_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_ld) begin
      out_vld_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      kind_r <= kind_nxt;
      fid_r  <= fid_nxt;
      wait_r <= wait_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_rsp.valid    = out_vld_r;
  assign out_rsp.kind     = kind_r;
  assign out_rsp.fired_id = fid_r;
  assign out_rsp.wait_ms  = wait_r;
  assign out_rsp.last     = last_r;

endmodule

### rtl/dtq_cell.sv
// Deadline timer queue: one cell of the sorted chain (valid, key, id).
// Depends on dtq_pkg; instantiated by dtq_chain.
module dtq_cell import dtq_pkg::*; #(
  parameter int IDX_W = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  chain_ctl_t        ctl,
  input  logic [TICK_W-1:0] ins_key,
  input  logic [IDX_W-1:0]  ins_id,
  input  logic              prev_cmp,
  input  logic              prev_vld,
  input  logic [TICK_W-1:0] prev_key,
  input  logic [IDX_W-1:0]  prev_id,
  input  logic              next_vld,
  input  logic [TICK_W-1:0] next_key,
  input  logic [IDX_W-1:0]  next_id,
  output logic              vld,
  output logic [TICK_W-1:0] key,
  output logic [IDX_W-1:0]  id,
  output logic              cmp
);

  logic              vld_r;
  logic [TICK_W-1:0] key_r;
  logic [IDX_W-1:0]  id_r;

  // new item belongs ahead of this cell's item (strict: equal keys keep id order)
  assign cmp = !vld_r || (ins_key < key_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.clr) begin
      vld_r <= 1'b0;
    end else if (ctl.pop) begin
      vld_r <= next_vld;
    end else if (ctl.ins && prev_cmp) begin
      vld_r <= prev_vld;
    end else if (ctl.ins && cmp) begin
      vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      key_r <= next_key;
      id_r  <= next_id;
    end else if (ctl.ins && prev_cmp) begin
      key_r <= prev_key;
      id_r  <= prev_id;
    end else if (ctl.ins && cmp) begin
      key_r <= ins_key;
      id_r  <= ins_id;
    end
  end

  assign vld = vld_r;
  assign key = key_r;
  assign id  = id_r;

endmodule

### rtl/dtq_chain.sv
// Deadline timer queue: row of sorting cells, smallest key at the head.
// Depends on dtq_pkg and dtq_cell.
module dtq_chain import dtq_pkg::*; #(
  parameter int TIMER_COUNT = TIMER_COUNT_DEF,
  parameter int IDX_W       = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  chain_ctl_t        ctl,
  input  logic [TICK_W-1:0] ins_key,
  input  logic [IDX_W-1:0]  ins_id,
  output logic              head_vld,
  output logic [TICK_W-1:0] head_key,
  output logic [IDX_W-1:0]  head_id
);

  logic              vld [TIMER_COUNT];
  logic [TICK_W-1:0] key [TIMER_COUNT];
  logic [IDX_W-1:0]  id  [TIMER_COUNT];
  logic              cmp [TIMER_COUNT];

  for (genvar i = 0; i < TIMER_COUNT; i++) begin : g_cell
    logic              p_cmp;
    logic              p_vld;
    logic [TICK_W-1:0] p_key;
    logic [IDX_W-1:0]  p_id;
    logic              n_vld;
    logic [TICK_W-1:0] n_key;
    logic [IDX_W-1:0]  n_id;

    if (i == 0) begin : g_first
      assign p_cmp = 1'b0;
      assign p_vld = 1'b0;
      assign p_key = '0;
      assign p_id  = '0;
    end else begin : g_mid
      assign p_cmp = cmp[i-1];
      assign p_vld = vld[i-1];
      assign p_key = key[i-1];
      assign p_id  = id[i-1];
    end

    if (i == TIMER_COUNT - 1) begin : g_last
      assign n_vld = 1'b0;
      assign n_key = '0;
      assign n_id  = '0;
    end else begin : g_body
      assign n_vld = vld[i+1];
      assign n_key = key[i+1];
      assign n_id  = id[i+1];
    end

    dtq_cell #(.IDX_W(IDX_W)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .ins_key  (ins_key),
      .ins_id   (ins_id),
      .prev_cmp (p_cmp),
      .prev_vld (p_vld),
      .prev_key (p_key),
      .prev_id  (p_id),
      .next_vld (n_vld),
      .next_key (n_key),
      .next_id  (n_id),
      .vld      (vld[i]),
      .key      (key[i]),
      .id       (id[i]),
      .cmp      (cmp[i])
    );
  end

  assign head_vld = vld[0];
  assign head_key = key[0];
  assign head_id  = id[0];

endmodule

### rtl/dtq_checker.sv
// Deadline timer queue: port-level assertions and their bind to the top.
// Depends on dtq_pkg and deadline_timer_queue.
module dtq_checker import dtq_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KIND_W-1:0] out_kind,
  input logic [TICK_W-1:0] out_wait_ms,
  input logic              out_last
);

  logic [1:0] open_r;

  // open requests: accepted, final result not yet taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 2'd0;
    end else if (in_valid && in_ready && !(out_valid && out_ready && out_last)) begin
      open_r <= open_r + 2'd1;
    end else if (!(in_valid && in_ready) && out_valid && out_ready && out_last) begin
      open_r <= open_r - 2'd1;
    end
  end

  // a new request may only overlap the previous one's final result
  a_one_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> open_r == 2'd0 || (open_r == 2'd1 && out_valid && out_last))
    else $error("request taken before the open one was fully answered");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> open_r != 2'd0)
    else $error("result without an open request");

  a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_ACK || out_kind == KIND_WAIT) |-> out_last)
    else $error("acknowledge or wait report not marked last");

  a_fire_body: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_FIRE |-> !out_last && out_wait_ms == '0)
    else $error("fired result marked last or carrying a wait");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_wait_ms))
    else $error("stalled result changed");

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_req.valid),
  .in_ready    (in_req.ready),
  .out_valid   (out_rsp.valid),
  .out_ready   (out_rsp.ready),
  .out_kind    (out_rsp.kind),
  .out_wait_ms (out_rsp.wait_ms),
  .out_last    (out_rsp.last)
);
